// ----- hdl/pcp_pkg.sv -----
`default_nettype none

package pcp_pkg;

  // Field widths of the stream payloads.
  localparam int SAMPLE_W   = 16;
  localparam int COEF_IDX_W = 6;
  localparam int COEF_W     = 16;
  localparam int CORR_W     = 39;
  localparam int DEV_W      = 23;
  localparam int MEAN_W     = 16;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 80;

  // Item kinds carried on in_tuser.
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_COEF = 1'b1;

  localparam logic signed [63:0] CORR_MAX = 64'sd274877906943;
  localparam logic signed [63:0] CORR_MIN = -64'sd274877906944;
  localparam logic [63:0]        DEV_MAX  = 64'd8388607;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM,
    ST_SUM_WAIT,
    ST_DIV,
    ST_CORR,
    ST_CORR_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;      // zero both stores at the sweep counter
    logic push;       // write the new sample at the head
    logic tpl_wr;     // write one template coefficient
    logic rd;         // read one window position and advance the counter
    logic corr;       // the read belongs to the correlation pass
    logic div_start;
    logic div_step;
    logic mean_ld;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic pipe_busy;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/pcp_ctrl.sv -----
`default_nettype none

module pcp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire logic          in_mode,
  output logic               in_tready,
  input  wire pcp_pkg::sts_t sts,
  output pcp_pkg::cmd_t      cmd
);
  import pcp_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.cnt_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid && in_mode == MODE_PUSH) state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (sts.cnt_last) state_nxt = ST_SUM_WAIT;
      end
      ST_SUM_WAIT: begin
        if (!sts.pipe_busy) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_CORR;
      end
      ST_CORR: begin
        if (sts.cnt_last) state_nxt = ST_CORR_WAIT;
      end
      ST_CORR_WAIT: begin
        if (!sts.pipe_busy) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.push   = in_tvalid && in_mode == MODE_PUSH;
        cmd.tpl_wr = in_tvalid && in_mode == MODE_COEF;
      end
      ST_SUM: begin
        cmd.rd = 1'b1;
      end
      ST_SUM_WAIT: begin
        cmd.div_start = !sts.pipe_busy;
      end
      ST_DIV: begin
        cmd.div_step = !sts.div_done;
        cmd.mean_ld  = sts.div_done;
      end
      ST_CORR: begin
        cmd.rd   = 1'b1;
        cmd.corr = 1'b1;
      end
      ST_CORR_WAIT: begin
        cmd.corr = 1'b1;
      end
      ST_DONE: begin
        cmd.out_ld = !sts.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/pcp_dp.sv -----
`default_nettype none

module pcp_dp #(
  parameter int WINDOW = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire pcp_pkg::cmd_t                          cmd,
  output pcp_pkg::sts_t                               sts,
  input  wire logic signed [pcp_pkg::SAMPLE_W-1:0]    sample,
  input  wire logic        [pcp_pkg::COEF_IDX_W-1:0]  coef_index,
  input  wire logic signed [pcp_pkg::COEF_W-1:0]      coef_value,
  output logic signed      [pcp_pkg::CORR_W-1:0]      correlation,
  output logic             [pcp_pkg::DEV_W-1:0]       deviation_power,
  output logic signed      [pcp_pkg::MEAN_W-1:0]      window_mean,
  output logic                                        out_valid,
  input  wire logic                                   out_ready
);
  import pcp_pkg::*;

  localparam int AW  = $clog2(WINDOW);
  localparam int SW  = SAMPLE_W + AW;        // window sum
  localparam int DW  = SAMPLE_W + 1;         // sample minus mean
  localparam int PW  = DW + COEF_W;          // one product
  localparam int CAW = PW + AW;              // correlation accumulator
  localparam int DAW = SAMPLE_W + AW;        // deviation accumulator
  localparam int RSH = SW + AW;              // reciprocal scaling shift
  localparam int RW  = SW + 1;               // reciprocal width
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << RSH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RW-1:0] RECIP = RW'(RECIP_WIDE);

  logic signed [SAMPLE_W-1:0] win_mem [WINDOW];
  logic signed [COEF_W-1:0]   tpl_mem [WINDOW];

  logic [AW-1:0] cnt_r, head_r;
  logic          cnt_last;
  logic [AW:0]   rot_sum;
  logic [AW-1:0] win_raddr;
  logic          tpl_in_range;

  logic signed [SAMPLE_W-1:0] win_q_r;
  logic signed [COEF_W-1:0]   tpl_q_r;

  logic                rd_v_r, rd_corr_r, s1_v_r, s2_v_r;
  logic signed [DW-1:0]     d_r;
  logic signed [COEF_W-1:0] t_r;
  logic signed [PW-1:0]     prod_r;
  logic [SAMPLE_W-1:0]      absd_r;

  logic signed [SW-1:0]  total_r;
  logic signed [CAW-1:0] corr_acc_r;
  logic [DAW-1:0]        dev_acc_r;

  logic [SW-1:0]            mag_r;
  logic                     neg_r;
  logic                     div_pend_r;
  logic [SW+RW-1:0]         quo_prod;
  logic [MEAN_W:0]          mean_mag_r;
  logic signed [MEAN_W-1:0] mean_r;

  logic signed [63:0] corr_wide;
  logic [63:0]        dev_wide;
  logic signed [CORR_W-1:0] corr_sat;
  logic [DEV_W-1:0]         dev_sat;

  assign cnt_last     = cnt_r == AW'(WINDOW - 1);
  assign rot_sum      = {1'b0, head_r} + {1'b0, cnt_r};
  assign win_raddr    = !cmd.corr ? cnt_r :
                        (rot_sum >= (AW + 1)'(WINDOW)) ? AW'(rot_sum - (AW + 1)'(WINDOW)) :
                        AW'(rot_sum);
  assign tpl_in_range = {26'd0, coef_index} < 32'(WINDOW);

  // Sweep counter for the clearing pass and both read passes; it wraps to
  // zero after each pass, so every pass starts at position zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      head_r <= '0;
    end else begin
      if (cmd.clear || cmd.rd) cnt_r <= cnt_last ? '0 : cnt_r + 1'b1;
      if (cmd.push) head_r <= (head_r == AW'(WINDOW - 1)) ? '0 : head_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      win_mem[cnt_r] <= '0;
    end else if (cmd.push) begin
      win_mem[head_r] <= sample;
    end
    win_q_r <= win_mem[win_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      tpl_mem[cnt_r] <= '0;
    end else if (cmd.tpl_wr && tpl_in_range) begin
      tpl_mem[AW'(coef_index)] <= coef_value;
    end
    tpl_q_r <= tpl_mem[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r    <= 1'b0;
      rd_corr_r <= 1'b0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
    end else begin
      rd_v_r    <= cmd.rd;
      rd_corr_r <= cmd.corr;
      s1_v_r    <= rd_v_r && rd_corr_r;
      s2_v_r    <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    d_r    <= DW'(win_q_r) - DW'(mean_r);
    t_r    <= tpl_q_r;
    prod_r <= d_r * t_r;
    absd_r <= d_r[DW-1] ? SAMPLE_W'(-d_r) : SAMPLE_W'(d_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      total_r    <= '0;
      corr_acc_r <= '0;
      dev_acc_r  <= '0;
    end else begin
      if (rd_v_r && !rd_corr_r) total_r <= total_r + SW'(win_q_r);
      if (s2_v_r) begin
        corr_acc_r <= corr_acc_r + CAW'(prod_r);
        dev_acc_r  <= dev_acc_r + DAW'(absd_r);
      end
    end
  end

  // The magnitude of the window sum is divided by WINDOW through one multiply
  // with the rounded-up reciprocal; with the shift chosen this way the
  // quotient is exact for every magnitude that fits in SW bits.
  assign quo_prod = (SW + RW)'(mag_r) * (SW + RW)'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_pend_r <= 1'b0;
    end else if (cmd.div_start) begin
      div_pend_r <= 1'b1;
    end else if (cmd.div_step) begin
      div_pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg_r <= total_r[SW-1];
      mag_r <= total_r[SW-1] ? SW'(-total_r) : SW'(total_r);
    end
    if (cmd.div_step) mean_mag_r <= (MEAN_W + 1)'(quo_prod >> RSH);
    if (cmd.mean_ld) mean_r <= neg_r ? MEAN_W'(-mean_mag_r) : MEAN_W'(mean_mag_r);
  end

  assign corr_wide = 64'(corr_acc_r);
  assign dev_wide  = 64'(dev_acc_r);

  always_comb begin
    if (corr_wide > CORR_MAX) begin
      corr_sat = CORR_W'(CORR_MAX);
    end else if (corr_wide < CORR_MIN) begin
      corr_sat = CORR_W'(CORR_MIN);
    end else begin
      corr_sat = CORR_W'(corr_wide);
    end
    dev_sat = (dev_wide > DEV_MAX) ? DEV_W'(DEV_MAX) : DEV_W'(dev_wide);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      correlation     <= corr_sat;
      deviation_power <= dev_sat;
      window_mean     <= mean_r;
    end
  end

  assign sts.cnt_last  = cnt_last;
  assign sts.pipe_busy = rd_v_r || s1_v_r || s2_v_r;
  assign sts.div_done  = !div_pend_r;
  assign sts.out_busy  = out_valid && !out_ready;

endmodule

`default_nettype wire

// ----- hdl/preamble_correlator_power.sv -----
`default_nettype none

// Mean-removed sliding correlator. A beat with in_tuser low pushes one sample
// into a window of the last WINDOW samples and yields one result beat: the
// window mean (sum divided by WINDOW, truncated toward zero), the correlation
// of the mean-removed window against the stored template (oldest sample with
// coefficient 0), and the sum of absolute deviations from the mean. A beat
// with in_tuser high writes one template coefficient and yields
// nothing; indexes at or above WINDOW are dropped. Items are handled one at a
// time: a push occupies the block through two passes over the window memory,
// a reciprocal multiply for the mean and the drain of the product pipeline.
// The finished result waits in an output register, so the next item is
// taken while it is still pending. After reset both stores are zeroed in a
// clearing pass before in_tready rises.
module preamble_correlator_power #(
  parameter int WINDOW = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // sample[15:0], coef_index[21:16], coef_value[37:22], zero fill above
  input  wire logic [pcp_pkg::IN_DATA_W-1:0]    in_tdata,
  // mode[0]
  input  wire logic                             in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // correlation[38:0], deviation_power[61:39], window_mean[77:62], zero fill above
  output logic [pcp_pkg::OUT_DATA_W-1:0]        out_tdata
);
  import pcp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic signed [CORR_W-1:0] correlation;
  logic        [DEV_W-1:0]  deviation_power;
  logic signed [MEAN_W-1:0] window_mean;

  pcp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pcp_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .sample          (in_tdata[15:0]),
    .coef_index      (in_tdata[21:16]),
    .coef_value      (in_tdata[37:22]),
    .correlation     (correlation),
    .deviation_power (deviation_power),
    .window_mean     (window_mean),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready)
  );

  assign out_tdata = {2'b00, window_mean, deviation_power, correlation};

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> !sts.out_busy)
    else $error("result loaded while the previous one is still pending");

  // The result is loaded only after the correlation pipeline has drained.
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> !sts.pipe_busy)
    else $error("result loaded with products still in flight");

  // A push keeps the input side closed for the following cycle.
  a_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == MODE_PUSH) |=> !in_tready)
    else $error("input accepted right after a sample push");

endmodule

`default_nettype wire
